>>> src/crcfr_pkg.sv
package crcfr_pkg;

   localparam logic [7:0] CR_BYTE = 8'h0D;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        is_last;
      logic [15:0] crc;
   } entry_type;

endpackage

>>> src/crcfr_front.sv
module crcfr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] data_byte
   input  logic                 req_tlast,
   input  logic                 csr_valid,
   input  logic [15:0]          csr_data,
   output logic                 push_valid,
   input  logic                 push_ready,
   output crcfr_pkg::entry_type push_entry
);

   localparam logic [15:0] POLY = 16'h1021;

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   logic [15:0] crc_start_ff, crc_start_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic        in_frame_ff, in_frame_in;
   logic [15:0] seed;
   logic [15:0] next_crc;
   logic        accept;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   assign seed     = in_frame_ff ? running_crc_ff : crc_start_ff;
   assign next_crc = crc_fold(seed, req_tdata);

   assign push_entry.data_byte = req_tdata;
   assign push_entry.is_last   = req_tlast;
   assign push_entry.crc       = next_crc;

   always_comb begin
      crc_start_in   = crc_start_ff;
      running_crc_in = running_crc_ff;
      in_frame_in    = in_frame_ff;
      if (csr_valid) begin
         crc_start_in = csr_data;
      end
      if (accept) begin
         running_crc_in = next_crc;
         in_frame_in    = !req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_start_ff   <= '0;
         running_crc_ff <= '0;
         in_frame_ff    <= 1'b0;
      end else begin
         crc_start_ff   <= crc_start_in;
         running_crc_ff <= running_crc_in;
         in_frame_ff    <= in_frame_in;
      end
   end

`ifndef SYNTHESIS
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> !in_frame_ff)
      else $error("frame not closed after last byte");

   a_body_opens_frame: assert property (@(posedge clock) disable iff (reset)
      accept && !req_tlast |=> in_frame_ff && running_crc_ff == $past(next_crc))
      else $error("running crc not carried");
`endif

endmodule

>>> src/crcfr_queue.sv
module crcfr_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  crcfr_pkg::entry_type in_entry,
   output logic                 out_valid,
   input  logic                 out_ready,
   output crcfr_pkg::entry_type out_entry
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   crcfr_pkg::entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push;
   logic          pop;

   assign in_ready  = count_ff != CW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_entry = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_entry;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count overflow");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count not decremented");
`endif

endmodule

>>> src/crcfr_back.sv
module crcfr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  crcfr_pkg::entry_type pop_entry,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [7:0] out_byte
   output logic                 rsp_tlast
);

   typedef enum logic [1:0] {
      PH_DATA,
      PH_HI,
      PH_LO,
      PH_CR
   } phase_type;

   phase_type   phase_ff;
   logic [15:0] crc_ff;
   logic        valid_ff;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic        free;

   assign free       = !valid_ff || rsp_tready;
   assign pop_ready  = free && (phase_ff == PH_DATA);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DATA;
         valid_ff <= 1'b0;
      end else if (free) begin
         case (phase_ff)
            PH_DATA: begin
               valid_ff <= pop_valid;
               byte_ff  <= pop_entry.data_byte;
               last_ff  <= 1'b0;
               crc_ff   <= pop_entry.crc;
               if (pop_valid && pop_entry.is_last) begin
                  phase_ff <= PH_HI;
               end
            end
            PH_HI: begin
               valid_ff <= 1'b1;
               byte_ff  <= crc_ff[15:8];
               last_ff  <= 1'b0;
               phase_ff <= PH_LO;
            end
            PH_LO: begin
               valid_ff <= 1'b1;
               byte_ff  <= crc_ff[7:0];
               last_ff  <= 1'b0;
               phase_ff <= PH_CR;
            end
            PH_CR: begin
               valid_ff <= 1'b1;
               byte_ff  <= crcfr_pkg::CR_BYTE;
               last_ff  <= 1'b1;
               phase_ff <= PH_DATA;
            end
            default: begin
               valid_ff <= 1'b0;
               phase_ff <= PH_DATA;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_last_is_cr: assert property (@(posedge clock) disable iff (reset)
      valid_ff && last_ff |-> byte_ff == crcfr_pkg::CR_BYTE)
      else $error("frame end without carriage return");

   a_trailer_valid: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_DATA |-> valid_ff)
      else $error("trailer pending with no byte on output");
`endif

endmodule

>>> src/crc16_command_framer.sv
// Command framer: each byte on req is forwarded on rsp and folded into a running
// CRC-16/XMODEM (poly 0x1021, MSB first, seeded from the value last written on csr).
// A byte flagged with req_tlast is followed on rsp by the CRC high byte, the CRC low
// byte and a carriage return, which alone carries rsp_tlast; the next byte starts a
// new frame. The byte CRC update is combinational, so req takes one byte per cycle
// while the queue has room. The output serializer sends one byte per cycle while
// rsp_tready is high, so a frame of N bytes goes out as N+3 bytes; a queue of
// QUEUE_DEPTH transactions (at least 2) lets req run on while the trailer goes out.
// An accepted byte passes the queue and the serializer's output register to rsp.
module crc16_command_framer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic                 push_valid;
   logic                 push_ready;
   crcfr_pkg::entry_type push_entry;
   logic                 pop_valid;
   logic                 pop_ready;
   crcfr_pkg::entry_type pop_entry;

   assign csr_ready = 1'b1;

   crcfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   crcfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   crcfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
